>>> sv/log2_newton_fixed_point_macros.svh
// Assertion helpers used by the RTL FIFO.
`ifndef LOG2_NEWTON_FIXED_POINT_MACROS_SVH
`define LOG2_NEWTON_FIXED_POINT_MACROS_SVH

// Same-cycle implication.
`define LNF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lnf assertion failed");

// Next-cycle implication.
`define LNF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lnf assertion failed");

`endif

>>> sv/lnf_pkg.sv
package lnf_pkg;

	localparam int DW = 64;
	localparam int SERIES_MAX = 64;
	localparam logic [63:0] LN2_Q62 = 64'h2C5C85FDF473DE6B;
	localparam logic [63:0] INVLN2_Q62 = 64'h5C551D94AE0BF85E;
	localparam int QDEPTH = 2;

	localparam logic [1:0] REG_NTOL = 2'd0;
	localparam logic [1:0] REG_STOL = 2'd1;
	localparam logic [1:0] REG_ICAP = 2'd2;

	typedef enum logic {
		MDU_MUL,
		MDU_DIV
	} mdu_op_t;

	typedef struct packed {
		logic start;
		mdu_op_t op;
		logic [DW-1:0] a;
		logic [DW-1:0] b;
	} mdu_req_t;

	typedef struct packed {
		logic done;
		logic [DW-1:0] result;
	} mdu_rsp_t;

	typedef struct packed {
		logic [20:0] log_result;
		logic zero_input;
		logic negative_input;
		logic not_converged;
	} res_item_t;

	function automatic logic [DW-1:0] mag64(input logic [DW-1:0] v);
		logic [DW-1:0] r;
		r = v[DW-1] ? (64'd0 - v) : v;
		return r;
	endfunction

endpackage

>>> sv/lnf_fifo.sv
`include "log2_newton_fixed_point_macros.svh"

module lnf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`LNF_ASSERT_NEXT(a_fill, clk, arst_n, do_push && !do_pop, count_q == $past(count_q) + CW'(1))
	`LNF_ASSERT_NEXT(a_drain, clk, arst_n, do_pop && !do_push, count_q == $past(count_q) - CW'(1))
	`LNF_ASSERT_NOW(a_ptrs, clk, arst_n, empty || full, wr_q == rd_q)
endmodule

>>> sv/lnf_front.sv
module lnf_front #(
	parameter int IN_WIDTH = 32,
	parameter int FRAC_BITS = 16,
	parameter int INNER_FRAC = 30,
	parameter int ITEM_W = 42
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic signed [IN_WIDTH-1:0] value_in,
	output logic                       full,
	output logic                       q_push,
	input  logic                       q_full,
	output logic [ITEM_W-1:0]          q_data
);
	import lnf_pkg::*;

	localparam int CW = $clog2(IN_WIDTH);
	localparam int RSH = (IN_WIDTH - 1 >= INNER_FRAC) ? (IN_WIDTH - 1 - INNER_FRAC) : 0;
	localparam int LSH = (IN_WIDTH - 1 >= INNER_FRAC) ? 0 : (INNER_FRAC - IN_WIDTH + 1);

	typedef enum logic [1:0] {
		F_IDLE,
		F_NORM,
		F_PUSH
	} fstate_t;

	fstate_t state_q;
	logic [IN_WIDTH-1:0] mag_q;
	logic [CW-1:0] cnt_q;
	logic neg_q, zero_q, one_q;

	logic in_neg, in_zero, in_one;
	logic [IN_WIDTH-1:0] in_mag;
	logic [DW-1:0] m64;
	logic [6:0] p;
	logic [7:0] k;

	assign in_neg = value_in[IN_WIDTH-1];
	assign in_mag = in_neg ? (IN_WIDTH'(0) - IN_WIDTH'(value_in)) : IN_WIDTH'(value_in);
	assign in_zero = (in_mag == '0);
	assign in_one = (DW'(in_mag) == (64'd1 << FRAC_BITS));

	assign full = (state_q != F_IDLE);
	assign q_push = (state_q == F_PUSH) && !q_full;

	assign m64 = (DW'(mag_q) >> RSH) << LSH;
	assign p = 7'(IN_WIDTH - 1) - 7'(cnt_q);
	assign k = 8'(p) - 8'(FRAC_BITS);
	assign q_data = {m64[INNER_FRAC:0], k, neg_q, zero_q, one_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			mag_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			zero_q <= 1'b0;
			one_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						mag_q <= in_mag;
						cnt_q <= '0;
						neg_q <= in_neg;
						zero_q <= in_zero;
						one_q <= in_one;
						state_q <= (in_zero || in_one) ? F_PUSH : F_NORM;
					end
				end
				F_NORM: begin
					if (mag_q[IN_WIDTH-1]) begin
						state_q <= F_PUSH;
					end else begin
						mag_q <= mag_q << 1;
						cnt_q <= cnt_q + CW'(1);
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end
endmodule

>>> sv/lnf_mdu.sv
module lnf_mdu #(
	parameter int INNER_FRAC = 30
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lnf_pkg::mdu_req_t req,
	output lnf_pkg::mdu_rsp_t rsp
);
	import lnf_pkg::*;

	typedef enum logic [1:0] {
		U_IDLE,
		U_MUL,
		U_DIV
	} ustate_t;

	ustate_t state_q;
	logic [DW-1:0] am_q, bm_q, acc_q, rem_q, n_q;
	logic [5:0] cnt_q;
	logic neg_q;
	mdu_rsp_t rsp_q;

	logic [DW-1:0] acc_next, prod;
	logic [DW:0] rem_sh;
	logic ge;
	logic [DW-1:0] rem_next, n_next;
	logic last_step;

	assign acc_next = acc_q
		+ (bm_q[0] ? am_q : '0)
		+ (bm_q[1] ? (am_q << 1) : '0)
		+ (bm_q[2] ? (am_q << 2) : '0)
		+ (bm_q[3] ? (am_q << 3) : '0);
	assign prod = acc_next >> INNER_FRAC;

	assign rem_sh = {rem_q, n_q[DW-1]};
	assign ge = (rem_sh >= {1'b0, bm_q});
	assign rem_next = ge ? DW'(rem_sh - {1'b0, bm_q}) : rem_sh[DW-1:0];
	assign n_next = {n_q[DW-2:0], ge};

	assign last_step = ((state_q == U_MUL) && (cnt_q == 6'd15))
		|| ((state_q == U_DIV) && (cnt_q == 6'd63));

	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			am_q <= '0;
			bm_q <= '0;
			acc_q <= '0;
			rem_q <= '0;
			n_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			rsp_q.done <= last_step;
			case (state_q)
				U_IDLE: begin
					if (req.start) begin
						cnt_q <= '0;
						if (req.op == MDU_MUL) begin
							am_q <= mag64(req.a);
							bm_q <= mag64(req.b);
							neg_q <= req.a[DW-1] ^ req.b[DW-1];
							acc_q <= '0;
							state_q <= U_MUL;
						end else begin
							n_q <= req.a;
							bm_q <= req.b;
							rem_q <= '0;
							state_q <= U_DIV;
						end
					end
				end
				U_MUL: begin
					acc_q <= acc_next;
					am_q <= am_q << 4;
					bm_q <= bm_q >> 4;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd15) begin
						rsp_q.result <= neg_q ? (64'd0 - prod) : prod;
						state_q <= U_IDLE;
					end
				end
				U_DIV: begin
					rem_q <= rem_next;
					n_q <= n_next;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						rsp_q.result <= n_next;
						state_q <= U_IDLE;
					end
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end
endmodule

>>> sv/lnf_back.sv
module lnf_back #(
	parameter int FRAC_BITS = 16,
	parameter int INNER_FRAC = 30,
	parameter int ITEM_W = 42
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [15:0]           ntol,
	input  logic [15:0]           stol,
	input  logic [6:0]            icap,
	input  logic                  q_empty,
	input  logic [ITEM_W-1:0]     q_data,
	output logic                  q_pop,
	input  logic                  o_full,
	output logic                  o_push,
	output lnf_pkg::res_item_t    o_data
);
	import lnf_pkg::*;

	localparam logic [DW-1:0] ONE = 64'd1 << INNER_FRAC;
	localparam logic [DW-1:0] QMAX = (64'd1 << (INNER_FRAC + 3)) - 64'd1;
	localparam logic signed [DW-1:0] XLIM = (64'sd1 <<< (INNER_FRAC + 1)) - 64'sd1;
	localparam logic [DW-1:0] LN2C =
		(LN2_Q62 + (64'd1 << (61 - INNER_FRAC))) >> (62 - INNER_FRAC);
	localparam logic [DW-1:0] INVLN2C =
		(INVLN2_Q62 + (64'd1 << (61 - INNER_FRAC))) >> (62 - INNER_FRAC);
	localparam int SHIFT = (INNER_FRAC > FRAC_BITS) ? (INNER_FRAC - FRAC_BITS) : 0;
	localparam logic [DW-1:0] HALF = (SHIFT > 0) ? (64'd1 << (SHIFT - 1)) : 64'd0;
	localparam logic signed [DW-1:0] RMAX = 64'sd1048575;
	localparam logic signed [DW-1:0] RMIN = -64'sd1048576;

	typedef enum logic [3:0] {
		B_IDLE,
		B_Y,
		B_TMUL,
		B_TDIV,
		B_QDIV,
		B_DMUL,
		B_FIN,
		B_OUT
	} bstate_t;

	bstate_t state_q;
	mdu_req_t req_q;
	mdu_rsp_t rsp;
	logic [INNER_FRAC:0] m_q;
	logic [7:0] k_q;
	logic neg_q, nc_q, tneg_q;
	logic [DW-1:0] x_q, y_q, sum_q;
	logic [6:0] f_q, i_q;
	logic [20:0] res_q;

	logic [INNER_FRAC:0] it_m;
	logic [7:0] it_k;
	logic it_neg, it_zero, it_one;
	logic zero_q;
	logic [DW-1:0] term_new, sum_new, s_div, q_sat, xsum, xn, m_sh;
	logic term_more, conv, issue;
	logic signed [DW-1:0] total, shr, rclip;

	lnf_mdu #(.INNER_FRAC(INNER_FRAC)) u_mdu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_q),
		.rsp   (rsp)
	);

	assign {it_m, it_k, it_neg, it_zero, it_one} = q_data;
	assign q_pop = (state_q == B_IDLE) && !q_empty && !o_full;
	assign o_push = (state_q == B_OUT);
	assign o_data.log_result = res_q;
	assign o_data.zero_input = zero_q;
	assign o_data.negative_input = neg_q;
	assign o_data.not_converged = nc_q;

	assign term_new = tneg_q ? (64'd0 - rsp.result) : rsp.result;
	assign sum_new = sum_q + term_new;
	assign term_more = (mag64(term_new) > DW'(stol)) && (f_q + 7'd1 <= 7'(SERIES_MAX));
	assign s_div = (sum_new[DW-1] || sum_new == '0) ? ONE : sum_new;
	assign m_sh = DW'(m_q) << INNER_FRAC;
	assign q_sat = (rsp.result > QMAX) ? QMAX : rsp.result;
	assign xsum = x_q + rsp.result;
	assign xn = ($signed(xsum) > XLIM) ? XLIM :
		($signed(xsum) < -XLIM - 64'sd1) ? (-XLIM - 64'sd1) : xsum;
	assign conv = mag64(xn - x_q) < DW'(ntol);

	assign issue = ((state_q == B_IDLE) && q_pop && !it_zero && !it_one && (icap != '0))
		|| ((state_q == B_DMUL) && rsp.done && !conv && (i_q + 7'd1 < icap))
		|| (rsp.done && ((state_q == B_Y) || (state_q == B_TMUL)
			|| (state_q == B_TDIV) || (state_q == B_QDIV)));

	assign total = $signed(x_q) + ($signed({{(DW-8){k_q[7]}}, k_q}) <<< INNER_FRAC);
	assign shr = (total + $signed(HALF)) >>> SHIFT;
	assign rclip = (shr > RMAX) ? RMAX : (shr < RMIN) ? RMIN : shr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			req_q <= '0;
			m_q <= '0;
			k_q <= '0;
			neg_q <= 1'b0;
			zero_q <= 1'b0;
			nc_q <= 1'b0;
			tneg_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			sum_q <= '0;
			f_q <= '0;
			i_q <= '0;
			res_q <= '0;
		end else begin
			req_q.start <= issue;
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						m_q <= it_m;
						k_q <= it_k;
						neg_q <= it_neg;
						zero_q <= it_zero;
						x_q <= DW'(it_m) >> 1;
						i_q <= '0;
						if (it_zero || it_one) begin
							res_q <= '0;
							nc_q <= 1'b0;
							state_q <= B_OUT;
						end else if (icap == '0) begin
							nc_q <= 1'b1;
							state_q <= B_FIN;
						end else begin
							req_q.op <= MDU_MUL;
							req_q.a <= DW'(it_m) >> 1;
							req_q.b <= LN2C;
							state_q <= B_Y;
						end
					end
				end
				B_Y: begin
					if (rsp.done) begin
						y_q <= rsp.result;
						sum_q <= ONE;
						f_q <= 7'd1;
						req_q.op <= MDU_MUL;
						req_q.a <= ONE;
						req_q.b <= rsp.result;
						state_q <= B_TMUL;
					end
				end
				B_TMUL: begin
					if (rsp.done) begin
						tneg_q <= rsp.result[DW-1];
						req_q.op <= MDU_DIV;
						req_q.a <= mag64(rsp.result);
						req_q.b <= DW'(f_q);
						state_q <= B_TDIV;
					end
				end
				B_TDIV: begin
					if (rsp.done) begin
						sum_q <= sum_new;
						f_q <= f_q + 7'd1;
						if (term_more) begin
							req_q.op <= MDU_MUL;
							req_q.a <= term_new;
							req_q.b <= y_q;
							state_q <= B_TMUL;
						end else begin
							req_q.op <= MDU_DIV;
							req_q.a <= m_sh;
							req_q.b <= s_div;
							state_q <= B_QDIV;
						end
					end
				end
				B_QDIV: begin
					if (rsp.done) begin
						req_q.op <= MDU_MUL;
						req_q.a <= q_sat - ONE;
						req_q.b <= INVLN2C;
						state_q <= B_DMUL;
					end
				end
				B_DMUL: begin
					if (rsp.done) begin
						x_q <= xn;
						i_q <= i_q + 7'd1;
						if (conv) begin
							nc_q <= 1'b0;
							state_q <= B_FIN;
						end else if (i_q + 7'd1 >= icap) begin
							nc_q <= 1'b1;
							state_q <= B_FIN;
						end else begin
							req_q.op <= MDU_MUL;
							req_q.a <= xn;
							req_q.b <= LN2C;
							state_q <= B_Y;
						end
					end
				end
				B_FIN: begin
					res_q <= rclip[20:0];
					state_q <= B_OUT;
				end
				B_OUT: begin
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end
endmodule

>>> sv/log2_newton_fixed_point.sv
// Base-2 logarithm of the magnitude of a signed Q16.16 value, returned as signed Q.16 with
// zero, negative and not-converged flags. Requests are pushed into a queue-like input and
// results are popped in order from a two-entry output queue. The front normalizes the
// magnitude one bit per cycle and hands it to the back through a two-entry queue; the
// back runs Newton-Raphson on one shared multiply/divide unit, evaluating a power series
// for each iteration. Zero and exactly one skip the normalization and the iteration.
module log2_newton_fixed_point #(
	parameter int IN_WIDTH = 32,
	parameter int FRAC_BITS = 16,
	parameter int INNER_FRAC = 30
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic signed [IN_WIDTH-1:0] value_in,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [20:0]         log_result,
	output logic                       zero_input,
	output logic                       negative_input,
	output logic                       not_converged,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import lnf_pkg::*;

	localparam int ITEM_W = INNER_FRAC + 12;
	localparam int RES_W = $bits(res_item_t);

	logic [15:0] ntol_q, stol_q;
	logic [6:0] icap_q;
	logic cfg_we;

	logic fq_push, fq_full, fq_empty, fq_pop;
	logic [ITEM_W-1:0] fq_wdata, fq_rdata;
	logic oq_push, oq_full;
	res_item_t oq_wdata, oq_rdata;
	logic [RES_W-1:0] oq_rbits;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ntol_q <= 16'd1;
			stol_q <= 16'd1;
			icap_q <= 7'd32;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_NTOL: ntol_q <= pwdata[15:0];
				REG_STOL: stol_q <= pwdata[15:0];
				REG_ICAP: icap_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_NTOL: prdata = {16'd0, ntol_q};
			REG_STOL: prdata = {16'd0, stol_q};
			REG_ICAP: prdata = {25'd0, icap_q};
			default: prdata = '0;
		endcase
	end

	lnf_front #(
		.IN_WIDTH  (IN_WIDTH),
		.FRAC_BITS (FRAC_BITS),
		.INNER_FRAC(INNER_FRAC),
		.ITEM_W    (ITEM_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.value_in(value_in),
		.full    (full),
		.q_push  (fq_push),
		.q_full  (fq_full),
		.q_data  (fq_wdata)
	);

	lnf_fifo #(.WIDTH(ITEM_W), .DEPTH(QDEPTH)) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fq_push),
		.wdata (fq_wdata),
		.pop   (fq_pop),
		.full  (fq_full),
		.empty (fq_empty),
		.rdata (fq_rdata)
	);

	lnf_back #(
		.FRAC_BITS (FRAC_BITS),
		.INNER_FRAC(INNER_FRAC),
		.ITEM_W    (ITEM_W)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.ntol   (ntol_q),
		.stol   (stol_q),
		.icap   (icap_q),
		.q_empty(fq_empty),
		.q_data (fq_rdata),
		.q_pop  (fq_pop),
		.o_full (oq_full),
		.o_push (oq_push),
		.o_data (oq_wdata)
	);

	lnf_fifo #(.WIDTH(RES_W), .DEPTH(QDEPTH)) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (oq_push),
		.wdata (oq_wdata),
		.pop   (pop),
		.full  (oq_full),
		.empty (empty),
		.rdata (oq_rbits)
	);

	assign oq_rdata = oq_rbits;
	assign log_result = oq_rdata.log_result;
	assign zero_input = oq_rdata.zero_input;
	assign negative_input = oq_rdata.negative_input;
	assign not_converged = oq_rdata.not_converged;
endmodule

>>> verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lnf_pkg::*;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic signed [31:0] value_in;
	logic empty;
	logic pop;
	logic signed [20:0] log_result;
	logic zero_input;
	logic negative_input;
	logic not_converged;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	log2_newton_fixed_point dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.value_in(value_in),
		.empty(empty),
		.pop(pop),
		.log_result(log_result),
		.zero_input(zero_input),
		.negative_input(negative_input),
		.not_converged(not_converged),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	localparam int ONE_Q = 30;
	localparam longint ONE_FX = longint'(1) <<< ONE_Q;

	res_item_t log_q[$];
	longint unsigned newton_tol;
	longint unsigned series_tol;
	longint unsigned iter_cap;
	int errors;
	int sent_count;
	int checked_count;
	int cfg_writes;
	bit calm;
	bit hold_go;
	int hold_left;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic longint unsigned mag_u(longint v);
		return v < 0 ? 64'd0 - longint'(v) : v;
	endfunction

	function automatic longint round_const(logic [63:0] c);
		return longint'((c + (64'd1 << 31)) >> 32);
	endfunction

	function automatic longint mul_fx(longint a, longint b);
		bit neg;
		longint unsigned prod;
		neg = (a < 0) != (b < 0);
		prod = (mag_u(a) * mag_u(b)) >> ONE_Q;
		return neg ? -longint'(prod) : longint'(prod);
	endfunction

	function automatic longint sat_x(longint v);
		longint lim;
		lim = (longint'(1) <<< (ONE_Q + 1)) - 1;
		if (v > lim) return lim;
		if (v < -lim - 1) return -lim - 1;
		return v;
	endfunction

	function automatic longint exp2_series(longint x);
		longint y;
		longint term;
		longint sum;
		longint f;
		y = mul_fx(x, round_const(LN2_Q62));
		term = ONE_FX;
		sum = ONE_FX;
		f = 1;
		do begin
			term = mul_fx(term, y) / f;
			sum += term;
			f++;
		end while (mag_u(term) > series_tol && f <= SERIES_MAX);
		return sum;
	endfunction

	function automatic longint newton_step(longint x, longint unsigned m);
		longint s;
		longint unsigned q;
		longint unsigned qmax;
		qmax = (64'd1 << (ONE_Q + 3)) - 1;
		s = exp2_series(x);
		if (s <= 0) s = ONE_FX;
		q = (m << ONE_Q) / longint'(s);
		if (q > qmax) q = qmax;
		return sat_x(x + mul_fx(longint'(q) - ONE_FX, round_const(INVLN2_Q62)));
	endfunction

	function automatic res_item_t predict_log2(logic [31:0] v);
		res_item_t r;
		longint unsigned mg;
		longint unsigned m;
		longint x;
		longint xn;
		longint total;
		longint result;
		longint k;
		longint unsigned i;
		int p;
		bit neg;
		bit conv;
		neg = v[31];
		mg = neg ? longint'({32'd0, 32'd0 - v}) : longint'({32'd0, v});
		result = 0;
		conv = 1'b1;
		if (mg != 0 && mg != (64'd1 << 16)) begin
			p = 63;
			while (p > 0 && mg[p] == 1'b0) p--;
			k = p - 16;
			if (p > ONE_Q) m = mg >> (p - ONE_Q);
			else m = mg << (ONE_Q - p);
			x = longint'(m >> 1);
			conv = 1'b0;
			for (i = 0; i < iter_cap; i++) begin
				xn = newton_step(x, m);
				if (mag_u(xn - x) < newton_tol) begin
					x = xn;
					conv = 1'b1;
					break;
				end
				x = xn;
			end
			total = x + k * ONE_FX + 8192;
			if (total >= 0) result = total >>> 14;
			else result = -longint'((mag_u(total) + 16383) >> 14);
			if (result > 1048575) result = 1048575;
			if (result < -1048576) result = -1048576;
		end
		r.log_result = result[20:0];
		r.zero_input = (mg == 0);
		r.negative_input = neg;
		r.not_converged = !conv;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
			checked_count);
		errors++;
	endtask

	always @(posedge clk) begin
		if (hold_go) begin
			hold_left <= 3000;
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= calm || ($urandom_range(99) >= 27);
		end
	end

	always @(negedge clk) begin
		res_item_t want;
		if (arst_n && pop && !empty) begin
			if (log_q.size() == 0) begin
				report_mismatch("unexpected result", 32'(log_result), 32'd0);
			end else begin
				want = log_q.pop_front();
				if (log_result !== want.log_result)
					report_mismatch("log_result", 32'(log_result), 32'(want.log_result));
				if (zero_input !== want.zero_input)
					report_mismatch("zero_input", 32'(zero_input), 32'(want.zero_input));
				if (negative_input !== want.negative_input)
					report_mismatch("negative_input", 32'(negative_input),
						32'(want.negative_input));
				if (not_converged !== want.not_converged)
					report_mismatch("not_converged", 32'(not_converged),
						32'(want.not_converged));
			end
			checked_count++;
		end
	end

	task automatic send_value(logic [31:0] v);
		bit taken;
		push <= 1'b1;
		value_in <= v;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !full;
			if (taken) log_q.push_back(predict_log2(v));
			@(posedge clk);
		end
		sent_count++;
		if (!calm && $urandom_range(99) < 27) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (log_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_NTOL: newton_tol = data & 32'hFFFF;
			REG_STOL: series_tol = data & 32'hFFFF;
			REG_ICAP: iter_cap = data & 32'h7F;
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic set_config(logic [31:0] nt, logic [31:0] st, logic [31:0] cap);
		wait_drained();
		write_reg(REG_NTOL, nt);
		write_reg(REG_STOL, st);
		write_reg(REG_ICAP, cap);
	endtask

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(7))
			0: v = $urandom;
			1: v = $urandom_range(0, 255);
			2: v = 32'd1 << $urandom_range(0, 31);
			3: v = 32'h10000 + $urandom_range(0, 64) - 32;
			4: v = 32'd0 - $urandom_range(0, 1 << 20);
			5: v = {1'b0, 31'($urandom)};
			6: v = {1'b1, 31'($urandom)};
			default: v = $urandom_range(0, 1 << 22);
		endcase
		return v;
	endfunction

	task automatic test_directed();
		logic [31:0] vals[$];
		vals = '{32'h0, 32'h10000, 32'hFFFF0000, 32'h80000000, 32'h7FFFFFFF, 32'h1,
			32'hFFFFFFFF, 32'h20000, 32'h8000, 32'h30000, 32'h00018000, 32'h0000FFFF,
			32'h00010001, 32'h40000000, 32'hC0000000, 32'h00000002};
		foreach (vals[j]) send_value(vals[j]);
	endtask

	task automatic test_config_extremes();
		set_config(1, 1, 0);
		send_value(32'h30000);
		send_value(32'h10000);
		send_value(32'h0);
		send_value(32'h80000000);
		set_config(0, 65535, 3);
		send_value(32'h50000);
		send_value(32'hFFFD0000);
		set_config(65535, 65535, 64);
		repeat (4) send_value(pick_value());
		set_config(1, 1, 64);
		repeat (3) send_value(pick_value());
	endtask

	task automatic test_backpressure();
		set_config(100, 4096, 4);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		repeat (4) send_value(32'h10000);
		repeat (4) send_value(32'h0);
		repeat (4) send_value(pick_value());
	endtask

	task automatic test_random();
		int unsigned nt;
		int unsigned st;
		for (int ph = 0; ph < 6; ph++) begin
			case ($urandom_range(2))
				0: nt = 1;
				1: nt = 65535;
				default: nt = $urandom_range(1, 65535);
			endcase
			case ($urandom_range(2))
				0: st = 1;
				1: st = 65535;
				default: st = $urandom_range(1, 65535);
			endcase
			set_config(nt, st, $urandom_range(1, 6));
			calm = (ph == 2);
			repeat (195) send_value(pick_value());
			calm = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		value_in = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_go = 1'b0;
		hold_left = 0;
		calm = 1'b0;
		errors = 0;
		sent_count = 0;
		checked_count = 0;
		cfg_writes = 0;
		newton_tol = 1;
		series_tol = 1;
		iter_cap = 32;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (100) @(posedge clk);
		$display("covered %0d requests, %0d results, %0d register writes", sent_count,
			checked_count, cfg_writes);
		$display("zero, unit, most negative, cap and tolerance extremes, output stall");
		if (errors == 0 && log_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#(64'd4000000000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
